### design/barometric_pressure_compensation_macros.svh
// Assertion macros shared by the pressure compensation design.
// Included by the top level only; depends on nothing else.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/bpc_pkg.sv
// Shared types, constants and helper functions of the pressure compensation block.
// Depends on nothing; used by the interfaces, the divider and the top level.
package bpc_pkg;

    typedef logic [31:0] w32_t;
    typedef logic [2:0]  cfg_idx_t;
    typedef logic [47:0] cfg_data_t;

    localparam int DIV_LAT = 32;
    localparam int NSTG    = 21 + 2 * DIV_LAT;

    localparam cfg_idx_t REG_OSS   = 3'd0;
    localparam cfg_idx_t REG_AC123 = 3'd1;
    localparam cfg_idx_t REG_AC456 = 3'd2;
    localparam cfg_idx_t REG_B12   = 3'd3;
    localparam cfg_idx_t REG_MCMD  = 3'd4;

    localparam w32_t K_B6_OFS  = 32'd4000;
    localparam w32_t K_SQ_MUL  = 32'd3038;
    localparam w32_t K_LIN_MUL = 32'hFFFF_E343;
    localparam w32_t K_OFS     = 32'd3791;
    localparam w32_t K_B7_MUL  = 32'd50000;
    localparam w32_t K_HALF    = 32'd32768;

    function automatic w32_t asr(input w32_t v, input logic [4:0] n);
        asr = w32_t'($signed(v) >>> n);
    endfunction

    function automatic w32_t sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

### design/bpc_if.sv
// Handshake interfaces for the input, result and configuration channels.
// Depends on bpc_pkg for the payload types.
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface bpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pressure_pa;
    logic signed [31:0] temperature_tenths;
    logic               divide_fault;
    modport source (output valid, output pressure_pa, output temperature_tenths,
                    output divide_fault, input ready);
    modport sink (input valid, input pressure_pa, input temperature_tenths,
                  input divide_fault, output ready);
endinterface

interface bpc_cfg_if;
    logic                 valid;
    logic                 ready;
    bpc_pkg::cfg_idx_t    index;
    bpc_pkg::cfg_data_t   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### design/bpc_div.sv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
// Depends on bpc_pkg; the whole pipe advances when en is high.
module bpc_div (
    input  logic          clk,
    input  logic          en,
    input  bpc_pkg::w32_t dividend,
    input  bpc_pkg::w32_t divisor,
    output bpc_pkg::w32_t quotient
);

    bpc_pkg::w32_t rem_reg [bpc_pkg::DIV_LAT];
    bpc_pkg::w32_t num_reg [bpc_pkg::DIV_LAT];
    bpc_pkg::w32_t quo_reg [bpc_pkg::DIV_LAT];
    bpc_pkg::w32_t den_reg [bpc_pkg::DIV_LAT];

    genvar i;
    generate
        for (i = 0; i < bpc_pkg::DIV_LAT; i++)
        begin : g_stage
            bpc_pkg::w32_t r_in;
            bpc_pkg::w32_t n_in;
            bpc_pkg::w32_t q_in;
            bpc_pkg::w32_t d_in;
            logic [32:0]   trial;
            logic [32:0]   diff;
            if (i == 0)
            begin : g_first
                assign r_in = '0;
                assign n_in = dividend;
                assign q_in = '0;
                assign d_in = divisor;
            end
            else
            begin : g_rest
                assign r_in = rem_reg[i-1];
                assign n_in = num_reg[i-1];
                assign q_in = quo_reg[i-1];
                assign d_in = den_reg[i-1];
            end
            assign trial = {r_in, n_in[31]};
            assign diff  = trial - {1'b0, d_in};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= diff[32] ? trial[31:0] : diff[31:0];
                    quo_reg[i] <= {q_in[30:0], ~diff[32]};
                    num_reg[i] <= {n_in[30:0], 1'b0};
                    den_reg[i] <= d_in;
                end
            end
        end
    endgenerate

    assign quotient = quo_reg[bpc_pkg::DIV_LAT-1];

endmodule

### design/barometric_pressure_compensation.sv
// Pressure and temperature compensation pipeline with calibration registers.
// Depends on bpc_pkg, the interfaces in bpc_if, bpc_div and the macro header.
// The block accepts one conversion every cycle unless a stalled result holds the pipeline;
// its 85 register stages are the two pipelined 32-stage dividers plus 21 arithmetic stages.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.
`include "barometric_pressure_compensation_macros.svh"

module barometric_pressure_compensation (
    input  logic      clk,
    input  logic      rst_n,
    bpc_in_if.sink    in_ch,
    bpc_out_if.source out_ch,
    bpc_cfg_if.sink   cfg_ch
);

    logic [1:0]    oss_reg;
    logic [47:0]   ac123_reg;
    logic [47:0]   ac456_reg;
    logic [31:0]   b12_reg;
    logic [31:0]   mcmd_reg;
    logic [bpc_pkg::NSTG-1:0] vld_reg;
    logic [bpc_pkg::NSTG-1:0] vld_next;
    logic          en;

    bpc_pkg::w32_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg   <= '0;
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                bpc_pkg::REG_OSS:   oss_reg   <= cfg_ch.data[1:0];
                bpc_pkg::REG_AC123: ac123_reg <= cfg_ch.data;
                bpc_pkg::REG_AC456: ac456_reg <= cfg_ch.data;
                bpc_pkg::REG_B12:   b12_reg   <= cfg_ch.data[31:0];
                bpc_pkg::REG_MCMD:  mcmd_reg  <= cfg_ch.data[31:0];
                default: ;
            endcase
        end
    end

    assign ac1 = bpc_pkg::sx16(ac123_reg[47:32]);
    assign ac2 = bpc_pkg::sx16(ac123_reg[31:16]);
    assign ac3 = bpc_pkg::sx16(ac123_reg[15:0]);
    assign ac4 = {16'd0, ac456_reg[47:32]};
    assign ac5 = {16'd0, ac456_reg[31:16]};
    assign ac6 = {16'd0, ac456_reg[15:0]};
    assign b1  = bpc_pkg::sx16(b12_reg[31:16]);
    assign b2  = bpc_pkg::sx16(b12_reg[15:0]);
    assign mc  = bpc_pkg::sx16(mcmd_reg[31:16]);
    assign md  = bpc_pkg::sx16(mcmd_reg[15:0]);

    assign en          = !vld_reg[bpc_pkg::NSTG-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign vld_next    = {vld_reg[bpc_pkg::NSTG-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    logic [15:0]   ut0_reg;
    bpc_pkg::w32_t up0_reg, prodA_reg, upA_reg, x1B_reg, denB_reg, upB_reg;
    bpc_pkg::w32_t x1C_reg, upC_reg, numC_reg, dvsC_reg;
    logic          f1C_reg, negC_reg;
    logic [3:0]    up_shift;

    assign up_shift = 4'd8 - {2'd0, oss_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ut0_reg   <= in_ch.raw_temperature;
            up0_reg   <= {8'd0, in_ch.raw_pressure} >> up_shift;
            prodA_reg <= ({16'd0, ut0_reg} - ac6) * ac5;
            upA_reg   <= up0_reg;
            x1B_reg   <= bpc_pkg::asr(prodA_reg, 5'd15);
            denB_reg  <= bpc_pkg::asr(prodA_reg, 5'd15) + md;
            upB_reg   <= upA_reg;
            x1C_reg   <= x1B_reg;
            upC_reg   <= upB_reg;
            f1C_reg   <= (denB_reg == '0);
            negC_reg  <= mc[31] ^ denB_reg[31];
            numC_reg  <= mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
            dvsC_reg  <= denB_reg[31] ? (32'd0 - denB_reg) : denB_reg;
        end
    end

    bpc_pkg::w32_t q1, q2;

    bpc_div u_div_t (
        .clk      (clk),
        .en       (en),
        .dividend (numC_reg),
        .divisor  (dvsC_reg),
        .quotient (q1)
    );

    logic [65:0] sd1_reg [bpc_pkg::DIV_LAT];
    logic [65:0] sd1_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd1_reg[0] <= {x1C_reg, upC_reg, f1C_reg, negC_reg};
            for (int k = 1; k < bpc_pkg::DIV_LAT; k++)
            begin
                sd1_reg[k] <= sd1_reg[k-1];
            end
        end
    end

    assign sd1_out = sd1_reg[bpc_pkg::DIV_LAT-1];

    bpc_pkg::w32_t b5D_reg, upD_reg, tE_reg, b6E_reg, upE_reg;
    bpc_pkg::w32_t sqF_reg, p2F_reg, p3F_reg, tF_reg, upF_reg;
    bpc_pkg::w32_t bsqG_reg, x2aG_reg, x1cG_reg, tG_reg, upG_reg;
    bpc_pkg::w32_t pb2H_reg, pb1H_reg, x2aH_reg, x1cH_reg, tH_reg, upH_reg;
    bpc_pkg::w32_t x3I_reg, x3cpI_reg, tI_reg, upI_reg;
    bpc_pkg::w32_t vJ_reg, x3cJ_reg, tJ_reg, upJ_reg;
    bpc_pkg::w32_t b3K_reg, pb4K_reg, tK_reg, upK_reg;
    bpc_pkg::w32_t b4L_reg, dL_reg, tL_reg;
    bpc_pkg::w32_t b7M_reg, b4M_reg, tM_reg;
    bpc_pkg::w32_t dvdN_reg, dvsN_reg, tN_reg;
    logic f1D_reg, f1E_reg, f1F_reg, f1G_reg, f1H_reg, f1I_reg, f1J_reg, f1K_reg;
    logic f1L_reg, f1M_reg, fN_reg, dblN_reg;
    bpc_pkg::w32_t x2D;

    assign x2D = sd1_out[0] ? (32'd0 - q1) : q1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5D_reg   <= sd1_out[65:34] + x2D;
            upD_reg   <= sd1_out[33:2];
            f1D_reg   <= sd1_out[1];
            tE_reg    <= bpc_pkg::asr(b5D_reg + 32'd8, 5'd4);
            b6E_reg   <= b5D_reg - bpc_pkg::K_B6_OFS;
            upE_reg   <= upD_reg;
            f1E_reg   <= f1D_reg;
            sqF_reg   <= b6E_reg * b6E_reg;
            p2F_reg   <= ac2 * b6E_reg;
            p3F_reg   <= ac3 * b6E_reg;
            tF_reg    <= tE_reg;
            upF_reg   <= upE_reg;
            f1F_reg   <= f1E_reg;
            bsqG_reg  <= bpc_pkg::asr(sqF_reg, 5'd12);
            x2aG_reg  <= bpc_pkg::asr(p2F_reg, 5'd11);
            x1cG_reg  <= bpc_pkg::asr(p3F_reg, 5'd13);
            tG_reg    <= tF_reg;
            upG_reg   <= upF_reg;
            f1G_reg   <= f1F_reg;
            pb2H_reg  <= b2 * bsqG_reg;
            pb1H_reg  <= b1 * bsqG_reg;
            x2aH_reg  <= x2aG_reg;
            x1cH_reg  <= x1cG_reg;
            tH_reg    <= tG_reg;
            upH_reg   <= upG_reg;
            f1H_reg   <= f1G_reg;
            x3I_reg   <= bpc_pkg::asr(pb2H_reg, 5'd11) + x2aH_reg;
            x3cpI_reg <= x1cH_reg + bpc_pkg::asr(pb1H_reg, 5'd16) + 32'd2;
            tI_reg    <= tH_reg;
            upI_reg   <= upH_reg;
            f1I_reg   <= f1H_reg;
            vJ_reg    <= (((ac1 << 2) + x3I_reg) << oss_reg) + 32'd2;
            x3cJ_reg  <= bpc_pkg::asr(x3cpI_reg, 5'd2);
            tJ_reg    <= tI_reg;
            upJ_reg   <= upI_reg;
            f1J_reg   <= f1I_reg;
            b3K_reg   <= bpc_pkg::asr(vJ_reg + (vJ_reg[31] ? 32'd3 : 32'd0), 5'd2);
            pb4K_reg  <= ac4 * (x3cJ_reg + bpc_pkg::K_HALF);
            tK_reg    <= tJ_reg;
            upK_reg   <= upJ_reg;
            f1K_reg   <= f1J_reg;
            b4L_reg   <= pb4K_reg >> 15;
            dL_reg    <= upK_reg - b3K_reg;
            tL_reg    <= tK_reg;
            f1L_reg   <= f1K_reg;
            b7M_reg   <= dL_reg * (bpc_pkg::K_B7_MUL >> oss_reg);
            b4M_reg   <= b4L_reg;
            tM_reg    <= tL_reg;
            f1M_reg   <= f1L_reg;
            fN_reg    <= f1M_reg || (b4M_reg == '0);
            dblN_reg  <= ~b7M_reg[31];
            dvdN_reg  <= b7M_reg[31] ? b7M_reg : (b7M_reg << 1);
            dvsN_reg  <= b4M_reg;
            tN_reg    <= tM_reg;
        end
    end

    bpc_div u_div_p (
        .clk      (clk),
        .en       (en),
        .dividend (dvdN_reg),
        .divisor  (dvsN_reg),
        .quotient (q2)
    );

    logic [33:0] sd2_reg [bpc_pkg::DIV_LAT];
    logic [33:0] sd2_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd2_reg[0] <= {tN_reg, fN_reg, dblN_reg};
            for (int k = 1; k < bpc_pkg::DIV_LAT; k++)
            begin
                sd2_reg[k] <= sd2_reg[k-1];
            end
        end
    end

    assign sd2_out = sd2_reg[bpc_pkg::DIV_LAT-1];

    bpc_pkg::w32_t pO_reg, tO_reg, p8P_reg, x2mP_reg, pP_reg, tP_reg;
    bpc_pkg::w32_t sqQ_reg, x2Q_reg, pQ_reg, tQ_reg, mR_reg, x2R_reg, pR_reg, tR_reg;
    bpc_pkg::w32_t sumS_reg, pS_reg, tS_reg, pT_reg, tT_reg;
    logic fO_reg, fP_reg, fQ_reg, fR_reg, fS_reg, fT_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pO_reg   <= sd2_out[0] ? q2 : (q2 << 1);
            tO_reg   <= sd2_out[33:2];
            fO_reg   <= sd2_out[1];
            p8P_reg  <= bpc_pkg::asr(pO_reg, 5'd8);
            x2mP_reg <= bpc_pkg::K_LIN_MUL * pO_reg;
            pP_reg   <= pO_reg;
            tP_reg   <= tO_reg;
            fP_reg   <= fO_reg;
            sqQ_reg  <= p8P_reg * p8P_reg;
            x2Q_reg  <= bpc_pkg::asr(x2mP_reg, 5'd16);
            pQ_reg   <= pP_reg;
            tQ_reg   <= tP_reg;
            fQ_reg   <= fP_reg;
            mR_reg   <= sqQ_reg * bpc_pkg::K_SQ_MUL;
            x2R_reg  <= x2Q_reg;
            pR_reg   <= pQ_reg;
            tR_reg   <= tQ_reg;
            fR_reg   <= fQ_reg;
            sumS_reg <= bpc_pkg::asr(mR_reg, 5'd16) + x2R_reg + bpc_pkg::K_OFS;
            pS_reg   <= pR_reg;
            tS_reg   <= tR_reg;
            fS_reg   <= fR_reg;
            pT_reg   <= fS_reg ? '0 : (pS_reg + bpc_pkg::asr(sumS_reg, 5'd4));
            tT_reg   <= fS_reg ? '0 : tS_reg;
            fT_reg   <= fS_reg;
        end
    end

    assign out_ch.valid              = vld_reg[bpc_pkg::NSTG-1];
    assign out_ch.pressure_pa        = pT_reg;
    assign out_ch.temperature_tenths = tT_reg;
    assign out_ch.divide_fault       = fT_reg;

    `BPC_ASSERT_IMPL(a_fault_zero, clk, rst_n, out_ch.valid && out_ch.divide_fault,
        out_ch.pressure_pa == 0 && out_ch.temperature_tenths == 0)
    `BPC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !en, $stable(vld_reg))
    `BPC_ASSERT_NEXT(a_drain, clk, rst_n, en && !in_ch.valid, !vld_reg[0])

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the barometric pressure compensation block.
// Depends on bpc_pkg and the interfaces in bpc_if; drives random traffic and checks every result.
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic signed [31:0] pa;
        logic signed [31:0] tenths;
        logic               fault;
    } reading_t;

    typedef struct {
        logic [15:0] ut;
        logic [23:0] up;
        logic        has_value;
        reading_t    value;
    } row_t;

    logic clk;
    logic rst_n;
    bpc_in_if  in_ch ();
    bpc_out_if out_ch ();
    bpc_cfg_if cfg_ch ();

    barometric_pressure_compensation DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    logic [1:0]  oss_q;
    logic [47:0] ac123_q;
    logic [47:0] ac456_q;
    logic [31:0] b12_q;
    logic [31:0] mcmd_q;

    reading_t pending_readings[$];
    int       mismatch_count;
    int       result_count;
    int       fault_count;
    bit       receiver_hold;
    bit       no_idle;
    row_t     rows[$];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic reading_t compensate(input logic [15:0] ut_in, input logic [23:0] up_in);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, bsq, p, t, den;
        r = '0;
        ac1 = bpc_pkg::sx16(ac123_q[47:32]);
        ac2 = bpc_pkg::sx16(ac123_q[31:16]);
        ac3 = bpc_pkg::sx16(ac123_q[15:0]);
        ac4 = {16'd0, ac456_q[47:32]};
        ac5 = {16'd0, ac456_q[31:16]};
        ac6 = {16'd0, ac456_q[15:0]};
        b1 = bpc_pkg::sx16(b12_q[31:16]);
        b2 = bpc_pkg::sx16(b12_q[15:0]);
        mc = bpc_pkg::sx16(mcmd_q[31:16]);
        md = bpc_pkg::sx16(mcmd_q[15:0]);
        ut = {16'd0, ut_in};
        up = {8'd0, up_in} >> (4'd8 - {2'd0, oss_q});
        x1 = bpc_pkg::asr((ut - ac6) * ac5, 5'd15);
        den = x1 + md;
        if (den == 32'd0)
        begin
            r.fault = 1'b1;
            return r;
        end
        x2 = sdiv(mc << 11, den);
        b5 = x1 + x2;
        t = bpc_pkg::asr(b5 + 32'd8, 5'd4);
        b6 = b5 - bpc_pkg::K_B6_OFS;
        bsq = bpc_pkg::asr(b6 * b6, 5'd12);
        x1 = bpc_pkg::asr(b2 * bsq, 5'd11);
        x2 = bpc_pkg::asr(ac2 * b6, 5'd11);
        x3 = x1 + x2;
        b3 = sdiv(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 32'd4);
        x1 = bpc_pkg::asr(ac3 * b6, 5'd13);
        x2 = bpc_pkg::asr(b1 * bsq, 5'd16);
        x3 = bpc_pkg::asr(x1 + x2 + 32'd2, 5'd2);
        b4 = (ac4 * (x3 + bpc_pkg::K_HALF)) >> 15;
        if (b4 == 32'd0)
        begin
            r.fault = 1'b1;
            return r;
        end
        b7 = (up - b3) * (bpc_pkg::K_B7_MUL >> oss_q);
        if (!b7[31])
            p = (b7 * 32'd2) / b4;
        else
            p = (b7 / b4) * 32'd2;
        x1 = bpc_pkg::asr(p, 5'd8) * bpc_pkg::asr(p, 5'd8);
        x1 = bpc_pkg::asr(x1 * bpc_pkg::K_SQ_MUL, 5'd16);
        x2 = bpc_pkg::asr(bpc_pkg::K_LIN_MUL * p, 5'd16);
        p = p + bpc_pkg::asr(x1 + x2 + bpc_pkg::K_OFS, 5'd4);
        r.pa = p;
        r.tenths = t;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            result_count++;
            if (out_ch.divide_fault)
                fault_count++;
            if (pending_readings.size() == 0)
                report_mismatch("unexpected result", out_ch.pressure_pa, 32'd0);
            else
            begin
                want = pending_readings.pop_front();
                if (out_ch.pressure_pa !== want.pa)
                    report_mismatch("pressure_pa", out_ch.pressure_pa, want.pa);
                if (out_ch.temperature_tenths !== want.tenths)
                    report_mismatch("temperature_tenths", out_ch.temperature_tenths,
                                    want.tenths);
                if (out_ch.divide_fault !== want.fault)
                    report_mismatch("divide_fault", {31'd0, out_ch.divide_fault},
                                    {31'd0, want.fault});
            end
        end
    end

    always @(negedge clk)
    begin
        if (receiver_hold)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= no_idle || ($urandom_range(99) >= 30);
    end

    task automatic write_reg(input bpc_pkg::cfg_idx_t idx, input bpc_pkg::cfg_data_t value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            bpc_pkg::REG_OSS:   oss_q = value[1:0];
            bpc_pkg::REG_AC123: ac123_q = value;
            bpc_pkg::REG_AC456: ac456_q = value;
            bpc_pkg::REG_B12:   b12_q = value[31:0];
            bpc_pkg::REG_MCMD:  mcmd_q = value[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Called at a falling edge; valid stays high until the next call or drain.
    task automatic send_conversion(input logic [15:0] ut, input logic [23:0] up);
        while (!no_idle && $urandom_range(99) < 30)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_temperature <= ut;
        in_ch.raw_pressure <= up;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_readings.push_back(compensate(ut, up));
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (bpc_pkg::NSTG + 10)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [15:0] ut, input logic [23:0] up, input bit known,
                           input reading_t value);
        row_t r;
        r.ut = ut;
        r.up = up;
        r.has_value = known;
        r.value = value;
        rows.push_back(r);
    endtask

    task automatic load_typical();
        write_reg(bpc_pkg::REG_AC123, {16'd408, 16'hFFD2, 16'hC6D9});
        write_reg(bpc_pkg::REG_AC456, {16'd32741, 16'd32757, 16'd23153});
        write_reg(bpc_pkg::REG_B12, {16'd0, 16'd6190, 16'd4});
        write_reg(bpc_pkg::REG_MCMD, {16'd0, 16'hD4BD, 16'd2868});
    endtask

    initial
    begin
        reading_t fault_value;
        mismatch_count = 0;
        result_count = 0;
        fault_count = 0;
        receiver_hold = 1'b0;
        no_idle = 1'b0;
        oss_q = '0;
        ac123_q = '0;
        ac456_q = '0;
        b12_q = '0;
        mcmd_q = '0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.raw_temperature = '0;
        in_ch.raw_pressure = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = bpc_pkg::REG_OSS;
        cfg_ch.data = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With all registers at reset, MD and X1 are zero, so every item faults.
        fault_value = '0;
        fault_value.fault = 1'b1;
        add_row(16'h0000, 24'h000000, 1'b1, fault_value);
        add_row(16'hFFFF, 24'hFFFFFF, 1'b1, fault_value);
        add_row(16'h5A5A, 24'hA5A5A5, 1'b1, fault_value);
        foreach (rows[i])
        begin
            if (rows[i].has_value && compensate(rows[i].ut, rows[i].up) !== rows[i].value)
                report_mismatch("directed table", 32'd0, 32'd0);
            send_conversion(rows[i].ut, rows[i].up);
        end
        drain();

        // Typical calibration, every oversampling mode, field extremes.
        load_typical();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(bpc_pkg::REG_OSS, 48'(m));
            send_conversion(16'd27898, 24'd23843 << 8);
            send_conversion(16'h0000, 24'h000000);
            send_conversion(16'hFFFF, 24'hFFFFFF);
            send_conversion(16'h8000, 24'h800000);
            drain();
        end

        // AC4 zero forces a zero pressure divisor.
        write_reg(bpc_pkg::REG_AC456, {16'd0, 16'd32757, 16'd23153});
        send_conversion(16'd27898, 24'h5D2300);
        drain();
        // Extreme coefficients.
        write_reg(bpc_pkg::REG_AC123, 48'hFFFF_FFFF_FFFF);
        write_reg(bpc_pkg::REG_AC456, 48'hFFFF_FFFF_FFFF);
        write_reg(bpc_pkg::REG_B12, 48'h0000_8000_7FFF);
        write_reg(bpc_pkg::REG_MCMD, 48'h0000_7FFF_8000);
        send_conversion(16'hFFFF, 24'hFFFFFF);
        send_conversion(16'h0000, 24'h000001);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(bpc_pkg::REG_OSS, 48'($urandom_range(3)));
            if (phase % 2 == 0)
            begin
                load_typical();
                write_reg(bpc_pkg::REG_AC123, {16'($urandom_range(65535)), ac123_q[31:0]});
            end
            else
            begin
                write_reg(bpc_pkg::REG_AC123, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_AC456, 48'({$urandom, $urandom}));
                write_reg(bpc_pkg::REG_B12, 48'($urandom));
                write_reg(bpc_pkg::REG_MCMD, 48'($urandom));
            end
            no_idle = (phase == 3);
            if (phase == 5)
                fork
                    begin
                        receiver_hold = 1'b1;
                        repeat (300)
                            @(posedge clk);
                        receiver_hold = 1'b0;
                    end
                join_none
            for (int k = 0; k < 120; k++)
            begin
                if ($urandom_range(9) < 7)
                    send_conversion(16'(16'd20000 + $urandom_range(16000)),
                                    24'(24'h400000 + $urandom_range(24'h300000)));
                else
                    send_conversion(16'($urandom), 24'($urandom));
            end
            drain();
            no_idle = 1'b0;
        end

        $display("checked %0d results, %0d with a divide fault, across all oversampling modes",
                 result_count, fault_count);
        if (mismatch_count == 0)
            $display("[barometric_pressure_compensation] OK");
        else
            $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_div.sv
design/barometric_pressure_compensation.sv
tb/sv/testbench.sv
